// File: sv/mte_pkg.sv
// shared types, constants and letter code table for the morse text encoder
package mte_pkg;

    // symbol codes carried on the output word
    typedef enum logic [1:0] {
        SYM_DOT   = 2'd0,
        SYM_DASH  = 2'd1,
        SYM_SPACE = 2'd2
    } t_symbol;

    localparam int CHAR_W       = 8;
    localparam int DOT_W        = 11;
    localparam int LED_W        = 13;
    localparam int PATTERN_BITS = 16;
    localparam int LETTERS      = 26;
    localparam int MAX_SYMS     = 5;
    localparam int MAX_ELEMS    = MAX_SYMS - 1;
    localparam int CNT_W        = $clog2(MAX_SYMS + 1);
    localparam int IDX_W        = $clog2(LETTERS);
    localparam int SYM_W        = 2;
    localparam int QDEPTH       = 4;
    localparam int QPTR_W       = $clog2(QDEPTH);
    localparam int SPACE_RUN    = 3;
    localparam logic [DOT_W-1:0] DOT_RESET = 11'd200;

    localparam logic [CHAR_W-1:0] CHAR_UPPER_A = 8'h41;
    localparam logic [CHAR_W-1:0] CHAR_UPPER_Z = 8'h5A;
    localparam logic [CHAR_W-1:0] CHAR_LOWER_A = 8'h61;
    localparam logic [CHAR_W-1:0] CHAR_LOWER_Z = 8'h7A;
    localparam logic [CHAR_W-1:0] CHAR_SPACE   = 8'h20;

    // one letter: number of elements and dash flags, element 0 first
    typedef struct packed {
        logic [CNT_W-1:0]     len;
        logic [MAX_ELEMS-1:0] dash;
    } t_letter_code;

    // one queued word group: symbol count and symbols, first in the low bits
    typedef struct packed {
        logic [CNT_W-1:0]          cnt;
        logic [MAX_SYMS*SYM_W-1:0] syms;
    } t_job;

    // scan an on/off pattern from the top bit: three ones make a dash,
    // a zero after one or two ones makes a dot (evaluated at elaboration)
    function automatic t_letter_code pattern_to_code(input logic [PATTERN_BITS-1:0] pat);
        t_letter_code code;
        int           run;
        int           n;
        code = '0;
        run  = 0;
        n    = 0;
        for (int b = PATTERN_BITS - 1; b >= 0; b--) begin
            if (pat[b]) begin
                if (run == 2) begin
                    if (n < MAX_ELEMS) begin
                        code.dash[n] = 1'b1;
                        n = n + 1;
                    end
                    run = 0;
                end else begin
                    run = run + 1;
                end
            end else if (run != 0) begin
                if (n < MAX_ELEMS) begin
                    n = n + 1;
                end
                run = 0;
            end
        end
        code.len = CNT_W'(n);
        return code;
    endfunction

    localparam t_letter_code LETTER_CODE [LETTERS] = '{
        pattern_to_code(16'hB800), pattern_to_code(16'hEA80), pattern_to_code(16'hEBA0),
        pattern_to_code(16'hEA00), pattern_to_code(16'h8000), pattern_to_code(16'hAE80),
        pattern_to_code(16'hEE80), pattern_to_code(16'hAA00), pattern_to_code(16'hA000),
        pattern_to_code(16'hBBB8), pattern_to_code(16'hEB80), pattern_to_code(16'hBA80),
        pattern_to_code(16'hEE00), pattern_to_code(16'hE800), pattern_to_code(16'hEEE0),
        pattern_to_code(16'hBBA0), pattern_to_code(16'hEEB8), pattern_to_code(16'hBA00),
        pattern_to_code(16'hA800), pattern_to_code(16'hE000), pattern_to_code(16'hAE00),
        pattern_to_code(16'hAB80), pattern_to_code(16'hBB80), pattern_to_code(16'hEAE0),
        pattern_to_code(16'hEBB8), pattern_to_code(16'hEEA0)
    };

endpackage

// File: sv/morse_text_encoder.sv
// morse text encoder top level: front end, symbol queue and back end
// an accepted byte passes through the queue and the group register before the output register
// throughput: one symbol per cycle while the output is not stalled; a letter or space byte
// gives 2 to 5 symbols at the output; other bytes are taken and give nothing
// a four-entry queue lets the input keep taking bytes while the output stalls
// reset (synchronous, active low) empties the queue and output, dot time is 200
module morse_text_encoder
    import mte_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_wr_en,
    input  logic [DOT_W-1:0]  i_cfg_wr_data,   // dot_time_ms
    input  logic              i_s_tvalid,
    output logic              o_s_tready,
    input  logic [CHAR_W-1:0] i_s_tdata,       // [7:0] char_code
    output logic              o_m_tvalid,
    input  logic              i_m_tready,
    output logic [15:0]       o_m_tdata,       // [1:0] symbol, [14:2] led_on_ms
    output logic              o_m_tlast        // last_of_run
);

    logic w_push;
    logic w_full;
    logic w_pop;
    logic w_empty;
    t_job w_push_job;
    t_job w_head_job;

    mte_front u_front (
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_q_full   (w_full),
        .o_q_push   (w_push),
        .o_q_job    (w_push_job)
    );

    mte_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_push_job),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_job   (w_head_job),
        .o_empty (w_empty)
    );

    mte_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_q_job       (w_head_job),
        .i_q_empty     (w_empty),
        .o_q_pop       (w_pop),
        .o_m_tvalid    (o_m_tvalid),
        .i_m_tready    (i_m_tready),
        .o_m_tdata     (o_m_tdata),
        .o_m_tlast     (o_m_tlast)
    );

endmodule

// File: sv/mte_front.sv
// front end: accepts bytes, classifies them and builds symbol groups
module mte_front
    import mte_pkg::*;
(
    input  logic              i_s_tvalid,
    output logic              o_s_tready,
    input  logic [CHAR_W-1:0] i_s_tdata,   // [7:0] char_code
    input  logic              i_q_full,
    output logic              o_q_push,
    output t_job              o_q_job
);

    logic [CHAR_W-1:0] w_diff;
    logic [IDX_W-1:0]  w_idx;
    logic              w_letter;
    logic              w_space;
    t_letter_code      w_code;

    // letter index, case folded
    always_comb begin
        w_letter = 1'b0;
        w_diff   = '0;
        if (i_s_tdata inside {[CHAR_UPPER_A:CHAR_UPPER_Z]}) begin
            w_letter = 1'b1;
            w_diff   = i_s_tdata - CHAR_UPPER_A;
        end else if (i_s_tdata inside {[CHAR_LOWER_A:CHAR_LOWER_Z]}) begin
            w_letter = 1'b1;
            w_diff   = i_s_tdata - CHAR_LOWER_A;
        end
        w_idx   = w_diff[IDX_W-1:0];
        w_space = (i_s_tdata == CHAR_SPACE);
        w_code  = LETTER_CODE[w_idx];
    end

    // symbol group: elements of the letter then one space, or a run of spaces
    always_comb begin
        o_q_job = '0;
        if (w_letter) begin
            o_q_job.cnt = w_code.len + CNT_W'(1);
            for (int i = 0; i < MAX_SYMS; i++) begin
                if (CNT_W'(i) < w_code.len) begin
                    o_q_job.syms[i*SYM_W +: SYM_W] = w_code.dash[i % MAX_ELEMS] ?
                                                     SYM_DASH : SYM_DOT;
                end else begin
                    o_q_job.syms[i*SYM_W +: SYM_W] = SYM_SPACE;
                end
            end
        end else begin
            o_q_job.cnt = CNT_W'(SPACE_RUN);
            for (int i = 0; i < MAX_SYMS; i++) begin
                o_q_job.syms[i*SYM_W +: SYM_W] = SYM_SPACE;
            end
        end
    end

    // bytes that give nothing are taken and dropped
    assign o_s_tready = !i_q_full;
    assign o_q_push   = i_s_tvalid && !i_q_full && (w_letter || w_space);

endmodule

// File: sv/mte_queue.sv
// small queue of symbol groups between front and back
module mte_queue
    import mte_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    output logic o_full,
    input  logic i_pop,
    output t_job o_job,
    output logic o_empty
);

    t_job              r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QPTR_W:0]   r_count;
    logic [QPTR_W:0]   n_count;
    logic              w_push;
    logic              w_pop;

    assign o_full  = (r_count == (QPTR_W+1)'(QDEPTH));
    assign o_empty = (r_count == '0);
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && !o_empty;
    assign o_job   = r_mem[r_rd_ptr];

    // occupancy
    always_comb begin
        n_count = r_count;
        if (w_push && !w_pop) begin
            n_count = r_count + 1'b1;
        end else if (w_pop && !w_push) begin
            n_count = r_count - 1'b1;
        end
    end

    // pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_count <= n_count;
            if (w_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

endmodule

// File: sv/mte_back.sv
// back end: plays out one symbol per cycle, while the output is not stalled, with its led on-time
module mte_back
    import mte_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_wr_en,
    input  logic [DOT_W-1:0] i_cfg_wr_data,
    input  t_job             i_q_job,
    input  logic             i_q_empty,
    output logic             o_q_pop,
    output logic             o_m_tvalid,
    input  logic             i_m_tready,
    output logic [15:0]      o_m_tdata,   // [1:0] symbol, [14:2] led_on_ms, [15] zero
    output logic             o_m_tlast    // last_of_run
);

    logic [DOT_W-1:0]          r_dot_ms;
    logic [CNT_W-1:0]          r_cnt;
    logic [MAX_SYMS*SYM_W-1:0] r_syms;
    logic                      r_valid;
    t_symbol                   r_sym;
    logic [LED_W-1:0]          r_led;
    logic                      r_last;

    logic [CNT_W-1:0]          n_cnt;
    logic [MAX_SYMS*SYM_W-1:0] n_syms;
    logic                      w_out_free;
    logic                      w_emit;
    t_symbol                   w_sym;
    logic [LED_W-1:0]          w_led;

    assign w_out_free = !r_valid || i_m_tready;
    assign w_emit     = w_out_free && (r_cnt != '0);
    assign o_q_pop    = !i_q_empty && ((r_cnt == '0) ||
                        ((r_cnt == CNT_W'(1)) && w_out_free));
    assign w_sym      = t_symbol'(r_syms[SYM_W-1:0]);

    // dot time register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dot_ms <= DOT_RESET;
        end else if (i_cfg_wr_en) begin
            r_dot_ms <= i_cfg_wr_data;
        end
    end

    // on-time of the symbol at the head of the group
    always_comb begin
        case (w_sym)
            SYM_DOT:  w_led = LED_W'(r_dot_ms);
            SYM_DASH: w_led = LED_W'(r_dot_ms) + (LED_W'(r_dot_ms) << 1);
            default:  w_led = '0;
        endcase
    end

    // current group: load from queue or shift out one symbol
    always_comb begin
        n_cnt  = r_cnt;
        n_syms = r_syms;
        if (o_q_pop) begin
            n_cnt  = i_q_job.cnt;
            n_syms = i_q_job.syms;
        end else if (w_emit) begin
            n_cnt  = r_cnt - CNT_W'(1);
            n_syms = r_syms >> SYM_W;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_syms <= n_syms;
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_out_free) begin
            r_valid <= w_emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_sym  <= w_sym;
            r_led  <= w_led;
            r_last <= (r_cnt == CNT_W'(1));
        end
    end

    assign o_m_tvalid = r_valid;
    assign o_m_tdata  = {1'b0, r_led, r_sym};
    assign o_m_tlast  = r_last;

`ifndef NO_ASSERTIONS
    // a word never carries the unused symbol code
    a_sym_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> (r_sym == SYM_DOT || r_sym == SYM_DASH || r_sym == SYM_SPACE))
        else $error("invalid symbol code");

    // spaces keep the led dark
    a_space_dark: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_sym == SYM_SPACE) |-> (r_led == '0))
        else $error("space with nonzero on-time");

    // every group ends on a space
    a_last_space: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_last) |-> (r_sym == SYM_SPACE))
        else $error("group ends on a non-space symbol");

    // a dash lasts three dots
    a_dash_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_sym == SYM_DASH) |-> (r_led == LED_W'(3 * r_dot_ms)))
        else $error("dash on-time mismatch");
`endif

endmodule
